>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> hw/rtl/qcit_pkg.sv
// ----------------------------------------------------------------------------
// qcit_pkg
// Types and constants shared by the quorum commit index tracker.
// ----------------------------------------------------------------------------
package qcit_pkg;

  localparam int unsigned IDX_W = 64;  // log index width
  localparam int unsigned MAJ_W = 5;   // width of a majority rank

  // Configuration register indexes
  localparam logic [2:0] REG_JOINT_MODE  = 3'd0;
  localparam logic [2:0] REG_ACTIVE      = 3'd1;
  localparam logic [2:0] REG_STABLE_VOT  = 3'd2;
  localparam logic [2:0] REG_OLD_MASK    = 3'd3;
  localparam logic [2:0] REG_NEW_MASK    = 3'd4;
  localparam logic [2:0] REG_OLD_VOT     = 3'd5;
  localparam logic [2:0] REG_NEW_VOT     = 3'd6;

  // Request kinds
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_EVAL   = 1'b1;

  // Control of one sorted index list
  typedef struct packed {
    logic start;  // load the first value and restart the list
    logic ins;    // insert a value in descending order
    logic pick;   // register the entry at the requested rank
  } qcit_sort_ctrl_t;

endpackage

>>> hw/rtl/qcit_topk.sv
// ----------------------------------------------------------------------------
// qcit_topk
// Row of registers holding collected indexes in descending order, filled one
// value per cycle, with a registered pick of the entry at a given rank.
// ----------------------------------------------------------------------------
module qcit_topk
  import qcit_pkg::*;
#(
  parameter int unsigned DEPTH = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  qcit_sort_ctrl_t  ctrl,
  input  logic [IDX_W-1:0] din,
  input  logic [MAJ_W-1:0] rank,    // zero-based rank from the largest
  output logic [IDX_W-1:0] pick_o,
  output logic             ok_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = $clog2(DEPTH);
  localparam int unsigned KW = (CW > MAJ_W) ? CW + 1 : MAJ_W + 1;

  logic [IDX_W-1:0] list_r [DEPTH];
  logic [IDX_W-1:0] list_nxt [DEPTH];
  logic [CW-1:0]    cnt_r;
  logic [DEPTH-1:0] keep;
  logic             rank_ok;
  logic [IDX_W-1:0] pick_r;
  logic             ok_r;

  // Entries that stay in place are a prefix of the valid part of the list.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (CW'(i) < cnt_r) && (list_r[i] >= din);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (keep[i]) begin
        list_nxt[i] = list_r[i];
      end else if (i == 0) begin
        list_nxt[i] = din;
      end else if (keep[i-1]) begin
        list_nxt[i] = din;
      end else begin
        list_nxt[i] = list_r[i-1];
      end
    end
  end

  assign rank_ok = KW'(rank) < KW'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ok_r  <= 1'b0;
    end else begin
      if (ctrl.start) begin
        cnt_r <= CW'(1);
      end else if (ctrl.ins) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (ctrl.pick) begin
        ok_r <= rank_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      list_r[0] <= din;
    end else if (ctrl.ins) begin
      list_r <= list_nxt;
    end
    if (ctrl.pick) begin
      pick_r <= rank_ok ? list_r[rank[LW-1:0]] : '0;
    end
  end

  assign pick_o = pick_r;
  assign ok_o   = ok_r;

endmodule

>>> hw/rtl/quorum_commit_index_tracker.sv
// ----------------------------------------------------------------------------
// quorum_commit_index_tracker
// Peer acknowledgment table and commit index with majority evaluation.
// ----------------------------------------------------------------------------
// A record item goes through one memory read, then one compare and write
// back. An evaluate item reads the active peer slots (at most PEERS) one per
// cycle, as the peer table sits in a memory with one read port, and inserts
// them into the sorted list of the stable set, or in joint mode into the
// lists of the old and new member sets, followed by the rank pick, the joint
// minimum and the commit update. One item is worked on at a time; a finished
// result may wait in the output register while the next item is accepted.
// The peer table reads as zero after reset through per-entry valid bits, so
// no clearing pass is needed.
`include "assert_macros.svh"

module quorum_commit_index_tracker
  import qcit_pkg::*;
#(
  parameter int unsigned PEERS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // peer_slot[2:0], peer_index[66:3],
                                   // snapshot_sent[67], leader_last_index[131:68]
  input  logic         in_tuser,   // req_type
  // Result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // committed index[63:0], advanced[64]
  // Configuration
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [7:0]   cfg_wdata
);

  localparam int unsigned IW = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int unsigned NW = $clog2(PEERS + 1);
  localparam int unsigned MW = (PEERS > 8) ? PEERS : 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REC,
    S_EVAL,
    S_PICK,
    S_MIN,
    S_DONE
  } state_t;

  // Configuration registers
  logic       joint_r;
  logic [3:0] active_r;
  logic [4:0] stable_vot_r;
  logic [7:0] old_mask_r;
  logic [7:0] new_mask_r;
  logic [4:0] old_vot_r;
  logic [4:0] new_vot_r;

  // Item fields
  logic             in_acc;
  logic             in_req;
  logic [2:0]       in_slot;
  logic [IDX_W-1:0] in_pidx;
  logic             in_snap;
  logic [IDX_W-1:0] in_leader;

  assign in_req    = in_tuser;
  assign in_slot   = in_tdata[2:0];
  assign in_pidx   = in_tdata[66:3];
  assign in_snap   = in_tdata[67];
  assign in_leader = in_tdata[131:68];

  state_t state_r, state_nxt;

  logic [IW-1:0]    slot_r;
  logic             slot_ok_r;
  logic [IDX_W-1:0] pidx_r;
  logic             snap_r;

  // Peer table
  logic [IDX_W-1:0] mem [PEERS];
  logic [PEERS-1:0] vld_r;
  logic [IW-1:0]    raddr;
  logic [IDX_W-1:0] rdata_r;
  logic             rvld_r;
  logic [IDX_W-1:0] peer_val;
  logic             mem_we;

  // Evaluation sequencing
  logic [NW-1:0]    rd_idx_r;
  logic [NW-1:0]    n_used;
  logic             rd_pend_r;
  logic             sel_a_r;
  logic             sel_b_r;
  logic [MW-1:0]    old_ext;
  logic [MW-1:0]    new_ext;

  qcit_sort_ctrl_t  ctrl_a;
  qcit_sort_ctrl_t  ctrl_b;
  logic [IDX_W-1:0] sort_din;
  logic [MAJ_W-1:0] rank_a;
  logic [MAJ_W-1:0] rank_b;
  logic [IDX_W-1:0] pick_a;
  logic [IDX_W-1:0] pick_b;
  logic             ok_a;
  logic             ok_b;

  logic [IDX_W-1:0] cand_r;
  logic             cand_ok_r;
  logic [IDX_W-1:0] committed_r;
  logic             adv;

  logic             out_tvalid_r;
  logic [IDX_W-1:0] out_commit_r;
  logic             out_adv_r;
  logic             out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_r      <= 1'b0;
      active_r     <= '0;
      stable_vot_r <= '0;
      old_mask_r   <= '0;
      new_mask_r   <= '0;
      old_vot_r    <= '0;
      new_vot_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_JOINT_MODE: joint_r      <= cfg_wdata[0];
        REG_ACTIVE:     active_r     <= cfg_wdata[3:0];
        REG_STABLE_VOT: stable_vot_r <= cfg_wdata[4:0];
        REG_OLD_MASK:   old_mask_r   <= cfg_wdata;
        REG_NEW_MASK:   new_mask_r   <= cfg_wdata;
        REG_OLD_VOT:    old_vot_r    <= cfg_wdata[4:0];
        REG_NEW_VOT:    new_vot_r    <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  assign n_used  = (5'(active_r) > 5'(PEERS)) ? NW'(PEERS) : NW'(active_r);
  assign old_ext = MW'(old_mask_r);
  assign new_ext = MW'(new_mask_r);

  // Zero-based rank of the majority: (voters + 1) / 2 + 1 - 1.
  assign rank_a = joint_r ? MAJ_W'((6'(old_vot_r) + 6'd1) >> 1)
                          : MAJ_W'((6'(stable_vot_r) + 6'd1) >> 1);
  assign rank_b = MAJ_W'((6'(new_vot_r) + 6'd1) >> 1);

  // ---------------------------------------------------------------------------
  // Peer table memory
  // ---------------------------------------------------------------------------
  assign raddr    = (state_r == S_IDLE) ? IW'(in_slot) : rd_idx_r[IW-1:0];
  assign peer_val = rvld_r ? rdata_r : '0;
  assign mem_we   = (state_r == S_REC) && slot_ok_r && (!snap_r || (pidx_r > peer_val));

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (mem_we) begin
      mem[slot_r] <= pidx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[raddr];
      if (mem_we) begin
        vld_r[slot_r] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sorted lists for the stable or old set (A) and the new set (B)
  // ---------------------------------------------------------------------------
  assign sort_din = (state_r == S_IDLE) ? in_leader : peer_val;

  always_comb begin
    ctrl_a.start = in_acc && (in_req == REQ_EVAL);
    ctrl_a.ins   = (state_r == S_EVAL) && rd_pend_r && sel_a_r;
    ctrl_a.pick  = (state_r == S_PICK);
    ctrl_b.start = ctrl_a.start;
    ctrl_b.ins   = (state_r == S_EVAL) && rd_pend_r && sel_b_r;
    ctrl_b.pick  = ctrl_a.pick;
  end

  qcit_topk #(
    .DEPTH (PEERS + 1)
  ) u_sort_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl_a),
    .din    (sort_din),
    .rank   (rank_a),
    .pick_o (pick_a),
    .ok_o   (ok_a)
  );

  qcit_topk #(
    .DEPTH (PEERS + 1)
  ) u_sort_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl_b),
    .din    (sort_din),
    .rank   (rank_b),
    .pick_o (pick_b),
    .ok_o   (ok_b)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_req == REQ_EVAL) ? S_EVAL : S_REC;
        end
      end
      S_REC: state_nxt = S_DONE;
      S_EVAL: begin
        if ((rd_idx_r == n_used) && !rd_pend_r) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: state_nxt = S_MIN;
      S_MIN:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign adv = cand_ok_r && (cand_r > committed_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_idx_r     <= '0;
      rd_pend_r    <= 1'b0;
      cand_ok_r    <= 1'b0;
      committed_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          rd_idx_r  <= '0;
          rd_pend_r <= 1'b0;
          cand_ok_r <= 1'b0;
        end
        S_EVAL: begin
          // A read issued in this cycle is inserted in the next one.
          if (rd_idx_r != n_used) begin
            rd_pend_r <= 1'b1;
            rd_idx_r  <= rd_idx_r + NW'(1);
          end else begin
            rd_pend_r <= 1'b0;
          end
        end
        S_MIN: begin
          // In joint mode a set short of indexes counts as zero.
          if (joint_r) begin
            cand_r    <= (pick_a < pick_b) ? pick_a : pick_b;
            cand_ok_r <= 1'b1;
          end else begin
            cand_r    <= pick_a;
            cand_ok_r <= ok_a;
          end
        end
        S_DONE: begin
          if (out_free && adv) begin
            committed_r <= cand_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r    <= IW'(in_slot);
      slot_ok_r <= 5'(in_slot) < 5'(PEERS);
      pidx_r    <= in_pidx;
      snap_r    <= in_snap;
    end
    if (state_r == S_EVAL) begin
      sel_a_r <= !joint_r || old_ext[rd_idx_r[IW-1:0]];
      sel_b_r <= joint_r && new_ext[rd_idx_r[IW-1:0]];
    end
    if ((state_r == S_DONE) && out_free) begin
      out_commit_r <= adv ? cand_r : committed_r;
      out_adv_r    <= adv;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_adv_r, out_commit_r};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_NEXT(a_commit_monotonic, clk, rst_n, rst_n, committed_r >= $past(committed_r))
  `ASSERT_IMPL(a_adv_nonzero, clk, rst_n, out_tvalid_r && out_adv_r, out_commit_r != '0)
  `ASSERT_IMPL(a_no_read_after_eval, clk, rst_n, state_r == S_PICK, !rd_pend_r && !mem_we)
  `ASSERT_IMPL(a_short_set_zero, clk, rst_n, (state_r == S_MIN) && !ok_b, pick_b == '0)

endmodule
